FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion helpers
// Clocked assertion shorthands used by the PS/2 frame shaper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/ps2kbd_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard transmitter package
// Shared sizes, codes, word types and status structs.
// ----------------------------------------------------------------------------
package ps2kbd_pkg;

  localparam int QUEUE_DEPTH    = 16;
  localparam int RESPONSE_DEPTH = 4;

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH);
  localparam int RCNT_W = $clog2(RESPONSE_DEPTH + 1);

  localparam int HALF_W  = 8;
  localparam int GAP_W   = 16;
  localparam int TICK_W  = 20;
  localparam int FRAME_W = 11;
  localparam int BIT_W   = $clog2(FRAME_W);
  localparam int SETTLE_HALVES = 4;
  localparam int PUSH_MAX = 3;

  localparam logic [BIT_W-1:0] FRAME_LAST_BIT = BIT_W'(FRAME_W - 1);

  // Word kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_MAKE  = 2'd1;
  localparam logic [1:0] KIND_BREAK = 2'd2;
  localparam logic [1:0] KIND_CMD   = 2'd3;

  // Host commands.
  localparam logic [7:0] CMD_ECHO     = 8'hEE;
  localparam logic [7:0] CMD_READ_ID  = 8'hF2;
  localparam logic [7:0] CMD_ENABLE   = 8'hF4;
  localparam logic [7:0] CMD_DISABLE  = 8'hF5;
  localparam logic [7:0] CMD_DEFAULTS = 8'hF6;
  localparam logic [7:0] CMD_RESET    = 8'hFF;

  // Device bytes.
  localparam logic [7:0] BYTE_ACK    = 8'hFA;
  localparam logic [7:0] BYTE_ECHO   = 8'hEE;
  localparam logic [7:0] BYTE_ID0    = 8'hAB;
  localparam logic [7:0] BYTE_ID1    = 8'h83;
  localparam logic [7:0] BYTE_BAT_OK = 8'hAA;
  localparam logic [7:0] BYTE_BREAK  = 8'hF0;

  // Configuration register indexes.
  localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] REG_GAP         = 2'd1;
  localparam logic [1:0] REG_RESET_DELAY = 2'd2;

  localparam logic [HALF_W-1:0] HALF_RESET  = HALF_W'(40);
  localparam logic [GAP_W-1:0]  GAP_RESET   = GAP_W'(2000);
  localparam logic [TICK_W-1:0] DELAY_RESET = TICK_W'(100000);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_SETUP   = 5'b00010,
    PH_CLKLOW  = 5'b00100,
    PH_CLKHIGH = 5'b01000,
    PH_SETTLE  = 5'b10000
  } phase_e;

  typedef enum logic [3:0] {
    BAT_NONE  = 4'b0001,
    BAT_WAIT  = 4'b0010,
    BAT_AFTER = 4'b0100,
    BAT_COUNT = 4'b1000
  } bat_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
  } in_word_t;

  typedef struct packed {
    logic       clock_low;
    logic       data_low;
    logic       accepted;
    logic       enabled;
    logic       busy_res;
    logic [3:0] queue_count;
  } out_word_t;

  typedef struct packed {
    logic [1:0]          n;
    logic [2:0][7:0]     bytes;
  } resp_push_t;

  typedef struct packed {
    logic [RCNT_W-1:0] cnt_q;
    logic [RCNT_W-1:0] cnt_d;
    logic              avail;
    logic              last;
    logic [7:0]        head;
  } resp_stat_t;

  typedef struct packed {
    logic [QCNT_W-1:0] cnt_d;
    logic              room_one;
    logic              room_two;
    logic              avail;
    logic [7:0]        head;
  } key_stat_t;

  typedef struct packed {
    logic clock_low;
    logic data_low;
    logic line_busy;
    logic seq_busy;
    logic seq_idle;
  } frame_stat_t;

  // Queue fill as shown on the result word, saturated at fifteen.
  function automatic logic [3:0] sat_count(logic [QCNT_W-1:0] c);
    return (int'(c) > 15) ? 4'd15 : 4'(c);
  endfunction

endpackage

FILE: design/ps2kbd_key_fifo.sv
// ----------------------------------------------------------------------------
// PS/2 key byte queue
// Circular byte queue; a key break writes the break prefix and the code.
// ----------------------------------------------------------------------------
module ps2kbd_key_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_one_i,
  input  logic                   push_two_i,
  input  logic [7:0]             code_i,
  input  logic                   pop_i,
  output ps2kbd_pkg::key_stat_t  stat_o
);

  logic [7:0] mem_q [ps2kbd_pkg::QUEUE_DEPTH];
  logic [ps2kbd_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d, wr_next;
  logic [ps2kbd_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [ps2kbd_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [ps2kbd_pkg::QPTR_W-1:0] ptr_inc(
    logic [ps2kbd_pkg::QPTR_W-1:0] p
  );
    return (p == ps2kbd_pkg::QPTR_W'(ps2kbd_pkg::QUEUE_DEPTH - 1)) ?
           '0 : p + 1'b1;
  endfunction

  assign wr_next = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_one_i) begin
      wr_ptr_d = wr_next;
      cnt_d    = cnt_q + 1'b1;
    end else if (push_two_i) begin
      wr_ptr_d = ptr_inc(wr_next);
      cnt_d    = cnt_q + ps2kbd_pkg::QCNT_W'(2);
    end else if (pop_i) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
      cnt_d    = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_one_i) begin
      mem_q[wr_ptr_q] <= code_i;
    end else if (push_two_i) begin
      mem_q[wr_ptr_q] <= ps2kbd_pkg::BYTE_BREAK;
      mem_q[wr_next]  <= code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // One slot always stays free, so capacity is one less than the depth.
  assign stat_o.cnt_d    = cnt_d;
  assign stat_o.room_one = cnt_q < ps2kbd_pkg::QCNT_W'(ps2kbd_pkg::QUEUE_DEPTH - 1);
  assign stat_o.room_two = cnt_q < ps2kbd_pkg::QCNT_W'(ps2kbd_pkg::QUEUE_DEPTH - 2);
  assign stat_o.avail    = cnt_q != '0;
  assign stat_o.head     = mem_q[rd_ptr_q];

endmodule

FILE: design/ps2kbd_resp_buf.sv
// ----------------------------------------------------------------------------
// PS/2 response buffer
// Small shifting buffer of command responses, sent ahead of key bytes.
// ----------------------------------------------------------------------------
module ps2kbd_resp_buf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ps2kbd_pkg::resp_push_t  push_i,
  input  logic                    pop_i,
  output ps2kbd_pkg::resp_stat_t  stat_o
);

  logic [7:0] slot_q [ps2kbd_pkg::RESPONSE_DEPTH];
  logic [7:0] slot_d [ps2kbd_pkg::RESPONSE_DEPTH];
  logic [7:0] eff    [ps2kbd_pkg::RESPONSE_DEPTH];
  logic [ps2kbd_pkg::RCNT_W-1:0] cnt_q, cnt_d, eff_cnt;

  // Pushed bytes land behind the stored ones; a pop then shifts the
  // combined contents down by one, so a byte can pass straight through.
  always_comb begin
    eff     = slot_q;
    eff_cnt = cnt_q + ps2kbd_pkg::RCNT_W'(push_i.n);
    for (int i = 0; i < ps2kbd_pkg::RESPONSE_DEPTH; i++) begin
      for (int k = 0; k < ps2kbd_pkg::PUSH_MAX; k++) begin
        if (k < int'(push_i.n) && i == int'(cnt_q) + k) begin
          eff[i] = push_i.bytes[k];
        end
      end
    end
    slot_d = eff;
    cnt_d  = eff_cnt;
    if (pop_i) begin
      for (int i = 0; i < ps2kbd_pkg::RESPONSE_DEPTH - 1; i++) begin
        slot_d[i] = eff[i+1];
      end
      cnt_d = eff_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign stat_o.cnt_q = cnt_q;
  assign stat_o.cnt_d = cnt_d;
  assign stat_o.avail = eff_cnt != '0;
  assign stat_o.last  = eff_cnt == ps2kbd_pkg::RCNT_W'(1);
  assign stat_o.head  = eff[0];

endmodule

FILE: design/ps2kbd_tx_frame.sv
// ----------------------------------------------------------------------------
// PS/2 frame shaper
// Bit timing of one serial frame, settle and gap, and the self-test delay.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ps2kbd_tx_frame (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              tick_i,
  input  logic                              bat_arm_i,
  input  logic [ps2kbd_pkg::HALF_W-1:0]     half_i,
  input  logic [ps2kbd_pkg::GAP_W-1:0]      gap_i,
  input  logic [ps2kbd_pkg::TICK_W-1:0]     delay_i,
  input  ps2kbd_pkg::resp_stat_t            resp_i,
  input  ps2kbd_pkg::key_stat_t             key_i,
  output logic                              pop_resp_o,
  output logic                              pop_key_o,
  output logic                              aa_push_o,
  output ps2kbd_pkg::frame_stat_t           stat_o
);

  ps2kbd_pkg::phase_e phase_q, phase_d, cur_phase;
  ps2kbd_pkg::bat_e   bat_q, bat_d, bat_a, bat_b;
  logic [ps2kbd_pkg::TICK_W-1:0]  ticks_q, ticks_d, cur_ticks, inc, limit, h, gap_ext;
  logic [ps2kbd_pkg::TICK_W-1:0]  bat_ticks_q, bat_ticks_d;
  logic [ps2kbd_pkg::BIT_W-1:0]   bit_q, bit_d, cur_bit;
  logic [ps2kbd_pkg::FRAME_W-1:0] shift_q, shift_d, cur_shift;
  logic                           sent_q, sent_d;
  logic                           idle, start, gap_ok, in_frame;
  logic [7:0]                     byte_sel;

  assign gap_ext = ps2kbd_pkg::TICK_W'(gap_i);

  always_comb begin
    h         = (half_i == '0) ? ps2kbd_pkg::TICK_W'(1) : ps2kbd_pkg::TICK_W'(half_i);
    idle      = phase_q == ps2kbd_pkg::PH_IDLE;
    bat_a     = bat_q;
    bat_ticks_d = bat_ticks_q;
    aa_push_o = 1'b0;

    // Self-test delay counts down only while the lines are idle.
    if (tick_i && idle && bat_q == ps2kbd_pkg::BAT_COUNT) begin
      if (bat_ticks_q == '0) begin
        aa_push_o = 1'b1;
        bat_a     = ps2kbd_pkg::BAT_NONE;
      end else begin
        bat_ticks_d = bat_ticks_q - 1'b1;
      end
    end

    gap_ok = !sent_q || ticks_q >= gap_ext;
    start  = tick_i && idle && bat_a != ps2kbd_pkg::BAT_COUNT &&
             (resp_i.avail || key_i.avail) && gap_ok;
    byte_sel   = resp_i.avail ? resp_i.head : key_i.head;
    pop_resp_o = start && resp_i.avail;
    pop_key_o  = start && !resp_i.avail;

    bat_b = bat_a;
    if (pop_resp_o && bat_a == ps2kbd_pkg::BAT_WAIT && resp_i.last) begin
      bat_b = ps2kbd_pkg::BAT_AFTER;
    end

    cur_phase = start ? ps2kbd_pkg::PH_SETUP : phase_q;
    cur_ticks = start ? '0 : ticks_q;
    cur_bit   = start ? '0 : bit_q;
    cur_shift = start ? {1'b1, ~^byte_sel, byte_sel, 1'b0} : shift_q;
    inc       = cur_ticks + 1'b1;
    limit     = (cur_phase == ps2kbd_pkg::PH_SETTLE) ?
                ps2kbd_pkg::TICK_W'(h * ps2kbd_pkg::SETTLE_HALVES) : h;

    phase_d = phase_q;
    ticks_d = ticks_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    sent_d  = sent_q;
    bat_d   = bat_arm_i ? ps2kbd_pkg::BAT_WAIT : bat_b;

    if (tick_i && idle && !start) begin
      // Idle time saturates instead of wrapping.
      if (ticks_q != '1) begin
        ticks_d = ticks_q + 1'b1;
      end
    end else if (tick_i) begin
      phase_d = cur_phase;
      bit_d   = cur_bit;
      shift_d = cur_shift;
      if (inc < limit) begin
        ticks_d = inc;
      end else begin
        ticks_d = '0;
        unique case (cur_phase)
          ps2kbd_pkg::PH_SETUP: begin
            phase_d = ps2kbd_pkg::PH_CLKLOW;
          end
          ps2kbd_pkg::PH_CLKLOW: begin
            phase_d = ps2kbd_pkg::PH_CLKHIGH;
          end
          ps2kbd_pkg::PH_CLKHIGH: begin
            if (cur_bit >= ps2kbd_pkg::FRAME_LAST_BIT) begin
              phase_d = ps2kbd_pkg::PH_SETTLE;
            end else begin
              bit_d   = cur_bit + 1'b1;
              phase_d = ps2kbd_pkg::PH_SETUP;
            end
          end
          ps2kbd_pkg::PH_SETTLE: begin
            phase_d = ps2kbd_pkg::PH_IDLE;
            shift_d = '1;
            bit_d   = '0;
            sent_d  = 1'b1;
            if (bat_b == ps2kbd_pkg::BAT_AFTER) begin
              bat_d       = ps2kbd_pkg::BAT_COUNT;
              bat_ticks_d = delay_i;
            end
          end
          default: begin
            phase_d = ps2kbd_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ps2kbd_pkg::PH_IDLE;
      bat_q       <= ps2kbd_pkg::BAT_NONE;
      ticks_q     <= '0;
      bat_ticks_q <= '0;
      bit_q       <= '0;
      shift_q     <= '1;
      sent_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      bat_q       <= bat_d;
      ticks_q     <= ticks_d;
      bat_ticks_q <= bat_ticks_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      sent_q      <= sent_d;
    end
  end

  assign in_frame = phase_d == ps2kbd_pkg::PH_SETUP ||
                    phase_d == ps2kbd_pkg::PH_CLKLOW ||
                    phase_d == ps2kbd_pkg::PH_CLKHIGH;

  assign stat_o.clock_low = phase_d == ps2kbd_pkg::PH_CLKLOW;
  assign stat_o.data_low  = (in_frame && bit_d < ps2kbd_pkg::BIT_W'(ps2kbd_pkg::FRAME_W)) ?
                            !shift_d[bit_d] : 1'b0;
  assign stat_o.line_busy = phase_d != ps2kbd_pkg::PH_IDLE || (sent_d && ticks_d < gap_ext);
  assign stat_o.seq_busy  = bat_d != ps2kbd_pkg::BAT_NONE;
  assign stat_o.seq_idle  = bat_q == ps2kbd_pkg::BAT_NONE;

  `ASSERT_IMPLIES(a_idle_lines_released, phase_q == ps2kbd_pkg::PH_IDLE, shift_q == '1 && bit_q == '0, "idle frame state not cleared")
  `ASSERT_IMPLIES(a_gap_before_frame, phase_q != ps2kbd_pkg::PH_IDLE && $past(phase_q == ps2kbd_pkg::PH_IDLE), $past(!sent_q || ticks_q >= gap_ext), "frame started inside the gap")
  `ASSERT_IMPLIES(a_no_frame_in_delay, bat_q == ps2kbd_pkg::BAT_COUNT, phase_q == ps2kbd_pkg::PH_IDLE, "frame active during self-test delay")

endmodule

FILE: design/ps2_keyboard_device_transmitter_unit.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard device transmitter
// Key and command front end with the device-to-host serial frame shaper.
// ----------------------------------------------------------------------------
// Usage: each input word carries a kind (tick, key make, key break, host
// command) and a code byte. Every accepted word yields exactly one result
// word with the line drive levels, the accept flag, the enable flag, a busy
// flag and the key queue fill. A word is taken when in_valid_i is high and
// in_stall_o low; a result is taken when out_valid_o is high and out_stall_i
// low. Ticks advance the frame timing; other kinds update the queues and
// device state. A word passes the input register, then all state updates and
// the result are computed in one pass into the result register. Throughput
// is one word per cycle unless the receiver stalls, set by that single-pass
// update path. When the receiver stalls, the result register holds its word
// and the input register holds one more; in_stall_o rises while both are
// full. Configuration writes are always ready and take effect for later
// words. Reset clears both queues, enables the device, releases both lines
// and restores the default timing registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ps2_keyboard_device_transmitter_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  ps2kbd_pkg::in_word_t   in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output ps2kbd_pkg::out_word_t  out_word_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [19:0]            cfg_data_i
);

  // Handshake and pipeline registers.
  logic                  in_valid_q;
  ps2kbd_pkg::in_word_t  in_word_q;
  logic                  out_valid_q;
  ps2kbd_pkg::out_word_t out_word_q, out_word_d;
  logic                  advance, fire, take_in;

  // Timing registers.
  logic [ps2kbd_pkg::HALF_W-1:0] half_q;
  logic [ps2kbd_pkg::GAP_W-1:0]  gap_q;
  logic [ps2kbd_pkg::TICK_W-1:0] delay_q;

  // Device state kept here: only the enable flag.
  logic enabled_q, enabled_d;

  // Decoded word.
  logic is_tick, is_make, is_break, is_cmd;
  logic acc_make, acc_break;
  logic cmd_take, bat_arm;
  int   need;

  ps2kbd_pkg::resp_push_t  cmd_push, resp_push;
  ps2kbd_pkg::resp_stat_t  resp_stat;
  ps2kbd_pkg::key_stat_t   key_stat;
  ps2kbd_pkg::frame_stat_t frame_stat;
  logic                    pop_resp, pop_key, aa_push;

  // The result register frees up when it is empty or being taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= take_in || (in_valid_q && !advance);
      out_valid_q <= fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_word_q <= in_word_i;
    end
    if (fire) begin
      out_word_q <= out_word_d;
    end
  end

  // Configuration port never pushes back; the user must let writes land while the block idles (not enforced).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= ps2kbd_pkg::HALF_RESET;
      gap_q   <= ps2kbd_pkg::GAP_RESET;
      delay_q <= ps2kbd_pkg::DELAY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ps2kbd_pkg::REG_HALF_PERIOD: half_q  <= cfg_data_i[ps2kbd_pkg::HALF_W-1:0];
        ps2kbd_pkg::REG_GAP:         gap_q   <= cfg_data_i[ps2kbd_pkg::GAP_W-1:0];
        ps2kbd_pkg::REG_RESET_DELAY: delay_q <= cfg_data_i[ps2kbd_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign is_tick  = fire && in_word_q.kind == ps2kbd_pkg::KIND_TICK;
  assign is_make  = fire && in_word_q.kind == ps2kbd_pkg::KIND_MAKE;
  assign is_break = fire && in_word_q.kind == ps2kbd_pkg::KIND_BREAK;
  assign is_cmd   = fire && in_word_q.kind == ps2kbd_pkg::KIND_CMD;

  // Key events need the device enabled and room for every byte they add.
  assign acc_make  = enabled_q && key_stat.room_one;
  assign acc_break = enabled_q && key_stat.room_two;

  // Host commands are dropped outright when the response buffer cannot
  // hold the full answer or a reset sequence is still running.
  always_comb begin
    need      = (in_word_q.code == ps2kbd_pkg::CMD_READ_ID) ? 3 : 1;
    cmd_take  = is_cmd && frame_stat.seq_idle &&
                (int'(resp_stat.cnt_q) + need <= ps2kbd_pkg::RESPONSE_DEPTH);
    enabled_d = enabled_q;
    bat_arm   = 1'b0;
    cmd_push  = '0;
    cmd_push.bytes[0] = ps2kbd_pkg::BYTE_ACK;
    if (cmd_take) begin
      cmd_push.n = 2'd1;
      case (in_word_q.code) inside
        ps2kbd_pkg::CMD_ECHO: begin
          cmd_push.bytes[0] = ps2kbd_pkg::BYTE_ECHO;
        end
        ps2kbd_pkg::CMD_READ_ID: begin
          cmd_push.n        = 2'd3;
          cmd_push.bytes[1] = ps2kbd_pkg::BYTE_ID0;
          cmd_push.bytes[2] = ps2kbd_pkg::BYTE_ID1;
        end
        ps2kbd_pkg::CMD_ENABLE, ps2kbd_pkg::CMD_DEFAULTS: begin
          enabled_d = 1'b1;
        end
        ps2kbd_pkg::CMD_DISABLE: begin
          enabled_d = 1'b0;
        end
        ps2kbd_pkg::CMD_RESET: begin
          bat_arm = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b1;
    end else begin
      enabled_q <= enabled_d;
    end
  end

  // The self-test pass byte only arrives on a tick, commands never do.
  always_comb begin
    resp_push = cmd_push;
    if (aa_push) begin
      resp_push          = '0;
      resp_push.n        = 2'd1;
      resp_push.bytes[0] = ps2kbd_pkg::BYTE_BAT_OK;
    end
  end

  ps2kbd_key_fifo u_key_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_one_i (is_make && acc_make),
    .push_two_i (is_break && acc_break),
    .code_i     (in_word_q.code),
    .pop_i      (pop_key),
    .stat_o     (key_stat)
  );

  ps2kbd_resp_buf u_resp_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (resp_push),
    .pop_i  (pop_resp),
    .stat_o (resp_stat)
  );

  ps2kbd_tx_frame u_tx_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (is_tick),
    .bat_arm_i  (bat_arm),
    .half_i     (half_q),
    .gap_i      (gap_q),
    .delay_i    (delay_q),
    .resp_i     (resp_stat),
    .key_i      (key_stat),
    .pop_resp_o (pop_resp),
    .pop_key_o  (pop_key),
    .aa_push_o  (aa_push),
    .stat_o     (frame_stat)
  );

  // The result reflects the state after this word has been applied.
  always_comb begin
    out_word_d.clock_low   = frame_stat.clock_low;
    out_word_d.data_low    = frame_stat.data_low;
    out_word_d.accepted    = is_make ? acc_make : (is_break ? acc_break : 1'b1);
    out_word_d.enabled     = enabled_d;
    out_word_d.busy_res    = frame_stat.line_busy || frame_stat.seq_busy ||
                             resp_stat.cnt_d != '0 || key_stat.cnt_d != '0;
    out_word_d.queue_count = ps2kbd_pkg::sat_count(key_stat.cnt_d);
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
